// File: rtl/core/fcid_pkg.sv
// ----------------------------------------------------------------------------
// fcid_pkg
// Shared types, constants and helpers of the community ID flow hash unit.
// ----------------------------------------------------------------------------
package fcid_pkg;

    localparam int ID_LEN = 30;
    localparam int ROUNDS = 80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } fcid_state_t;

    typedef struct packed {
        logic load;
        logic round;
        logic final_add;
        logic emit;
    } fcid_cmd_t;

    typedef struct packed {
        logic round_last;
        logic char_last;
    } fcid_status_t;

    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;

    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
    localparam logic [4:0] LAST_CHAR  = 5'(ID_LEN - 1);

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
            r = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            r = 8'h61 + {2'b00, v} - 8'd26;
        else if (v < 6'd62)
            r = 8'h30 + {2'b00, v} - 8'd52;
        else if (v == 6'd62)
            r = 8'h2B;
        else
            r = 8'h2F;
        return r;
    endfunction

endpackage

// File: rtl/core/fcid_ctrl.sv
// ----------------------------------------------------------------------------
// fcid_ctrl
// Sequencer: load block, run SHA-1 rounds, final add, emit 30 characters.
// ----------------------------------------------------------------------------
module fcid_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  out_fire,
    input  fcid_pkg::fcid_status_t status,
    output fcid_pkg::fcid_cmd_t   cmd,
    output logic                  busy,
    output logic                  emitting
);
    import fcid_pkg::*;

    fcid_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_LOAD:
                state_next = ST_ROUND;
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.round_last)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                cmd.final_add = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    cmd.emit = 1'b1;
                    if (status.char_last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy     = (state_reg != ST_IDLE);
    assign emitting = (state_reg == ST_EMIT);

    a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load outside idle");
    a_final_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINAL |-> $past(state_reg) == ST_ROUND)
        else $error("final without rounds");
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_fire && status.char_last) |=> state_reg == ST_IDLE)
        else $error("did not return to idle");
endmodule

// File: rtl/core/fcid_dp.sv
// ----------------------------------------------------------------------------
// fcid_dp
// Datapath: canonical ordering, block build, SHA-1 round unit, base64 output.
// ----------------------------------------------------------------------------
module fcid_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fcid_pkg::fcid_cmd_t   cmd,
    input  logic [15:0]           hash_seed,
    input  logic [64*4+16+16+8:0] tuple,
    output fcid_pkg::fcid_status_t status,
    output logic [7:0]            id_char,
    output logic                  last_char
);
    import fcid_pkg::*;

    logic [63:0] sh, sl, dh, dl;
    logic [15:0] sp, dp;
    logic [7:0]  proto;
    logic        v6;
    logic        keep;
    logic [63:0] ah, al, bh, bl;
    logic [15:0] ap, bp;
    logic [511:0] blk;

    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  rnd_reg;
    logic [4:0]  chr_reg;
    logic [159:0] dig_reg;

    logic [31:0] f, k, t, wn;
    logic [167:0] dig_pad;
    logic [5:0]  sext;

    assign v6    = tuple[64*4+16+16+8];
    assign proto = tuple[64*4+32 +: 8];
    assign dp    = tuple[64*4+16 +: 16];
    assign sp    = tuple[64*4 +: 16];
    assign dl    = v6 ? tuple[192 +: 64] : {32'd0, tuple[192 +: 32]};
    assign dh    = v6 ? tuple[128 +: 64] : 64'd0;
    assign sl    = v6 ? tuple[64 +: 64]  : {32'd0, tuple[64 +: 32]};
    assign sh    = v6 ? tuple[0 +: 64]   : 64'd0;

    always_comb
    begin
        keep = (sh < dh) || (sh == dh && sl < dl) || (sh == dh && sl == dl && sp < dp);
        ah = keep ? sh : dh;
        al = keep ? sl : dl;
        ap = keep ? sp : dp;
        bh = keep ? dh : sh;
        bl = keep ? dl : sl;
        bp = keep ? dp : sp;
        if (v6)
            blk = {hash_seed, ah, al, bh, bl, proto, 8'd0, ap, bp, 8'h80,
                   120'd0, 64'd320};
        else
            blk = {hash_seed, al[31:0], bl[31:0], proto, 8'd0, ap, bp, 8'h80,
                   312'd0, 64'd128};
    end

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        t  = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + w_reg[0];
        wn = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wn = {wn[30:0], wn[31]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg <= '0;
            chr_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                rnd_reg <= '0;
            else if (cmd.round)
                rnd_reg <= rnd_reg + 7'd1;
            if (cmd.final_add)
                chr_reg <= '0;
            else if (cmd.emit)
                chr_reg <= chr_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= blk[511 - 32*i -: 32];
            a_reg <= 32'h67452301;
            b_reg <= 32'hEFCDAB89;
            c_reg <= 32'h98BADCFE;
            d_reg <= 32'h10325476;
            e_reg <= 32'hC3D2E1F0;
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wn;
            a_reg <= t;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.final_add)
            dig_reg <= {a_reg + 32'h67452301, b_reg + 32'hEFCDAB89,
                        c_reg + 32'h98BADCFE, d_reg + 32'h10325476,
                        e_reg + 32'hC3D2E1F0};
        else if (cmd.emit && chr_reg >= 5'd2)
            dig_reg <= {dig_reg[153:0], 6'd0};
    end

    assign dig_pad = {dig_reg, 8'd0};
    assign sext    = dig_pad[167 -: 6];

    always_comb
    begin
        if (chr_reg == 5'd0)
            id_char = CHAR_ONE;
        else if (chr_reg == 5'd1)
            id_char = CHAR_COLON;
        else if (chr_reg == LAST_CHAR)
            id_char = CHAR_PAD;
        else
            id_char = b64_char(sext);
    end

    assign last_char         = (chr_reg == LAST_CHAR);
    assign status.round_last = (rnd_reg == LAST_ROUND);
    assign status.char_last  = (chr_reg == LAST_CHAR);
endmodule

// File: rtl/core/flow_community_id_v1_unit.sv
// ----------------------------------------------------------------------------
// flow_community_id_v1_unit
// Community ID v1 flow hash: one tuple in, 30 ASCII characters out.
// ----------------------------------------------------------------------------
// One flow tuple per transaction; the unit orders the endpoints, hashes the
// tuple with one SHA-1 block (one round per clock) and streams "1:" plus the
// base64 digest. An item goes through load, the rounds, the final add and the
// output characters, which backpressure can hold. A new tuple is taken once
// the last character has been delivered.
module flow_community_id_v1_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // src_addr_high, src_addr_low, dst_addr_high, dst_addr_low, src_port,
    // dst_port, ip_protocol, is_ipv6, zero fill
    input  logic [303:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // id_char
    output logic [7:0]   m_tdata,
    output logic         m_tlast
);
    import fcid_pkg::*;

    logic [15:0]  hash_seed_reg;
    fcid_cmd_t    cmd;
    fcid_status_t status;
    logic         busy, emitting, in_fire, out_fire;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {16'd0, hash_seed_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_seed_reg <= '0;
        else if (psel && penable && pwrite && paddr == 1'b0)
            hash_seed_reg <= pwdata[15:0];
    end

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = emitting;
    assign out_fire = m_tvalid && m_tready;

    fcid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .emitting (emitting)
    );

    fcid_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .hash_seed (hash_seed_reg),
        .tuple     (s_tdata[296:0]),
        .status    (status),
        .id_char   (m_tdata),
        .last_char (m_tlast)
    );
endmodule
